[hw/rtl/sgcs_pkg.sv]
`default_nettype none
// ============================================================================
// sgcs_pkg
// Shared types, codes and constants of the snow grid sweep unit.
// ============================================================================
package sgcs_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int UW_W        = 8;
    localparam int UH_W        = 7;
    localparam int SEED_W      = 16;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_EMPTY  = 2'd0;
    localparam logic [1:0] KIND_FLAKE  = 2'd1;
    localparam logic [1:0] KIND_WALL   = 2'd2;
    localparam logic [1:0] KIND_CANNON = 2'd3;

    localparam logic [2:0] OP_WRITE       = 3'd0;
    localparam logic [2:0] OP_DROP_COL    = 3'd1;
    localparam logic [2:0] OP_DROP_CANNON = 3'd2;
    localparam logic [2:0] OP_LEFT        = 3'd3;
    localparam logic [2:0] OP_RIGHT       = 3'd4;
    localparam logic [2:0] OP_TICK        = 3'd5;
    localparam logic [2:0] OP_READ        = 3'd6;
    localparam logic [2:0] OP_NONE        = 3'd7;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SEED   = 2'd2;

    localparam logic [UW_W-1:0]   RST_WIDTH  = UW_W'(MAX_COLUMNS);
    localparam logic [UH_W-1:0]   RST_HEIGHT = UH_W'(MAX_ROWS);
    localparam logic [SEED_W-1:0] RST_SEED   = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_MASK  = 16'hB400;

    typedef logic [MAX_COLUMNS-1:0][1:0] row_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             wall;
        logic             col_in;
        logic             cell_in;
    } cmd_t;

    typedef struct packed {
        logic              width_wr;
        logic [UW_W-1:0]   width_new;
        logic              seed_wr;
        logic [SEED_W-1:0] seed;
    } cfg_evt_t;

    typedef struct packed {
        logic             busy;
        logic [COL_W-1:0] cannon;
    } back_stat_t;

    function automatic logic [UW_W-1:0] clamp_width(input logic [UW_W-1:0] w);
        logic [UW_W-1:0] r;
        r = w;
        if (w == '0) r = UW_W'(1);
        else if (w > UW_W'(MAX_COLUMNS)) r = UW_W'(MAX_COLUMNS);
        return r;
    endfunction

    function automatic logic [UH_W-1:0] clamp_height(input logic [UH_W-1:0] h);
        logic [UH_W-1:0] r;
        r = h;
        if (h < UH_W'(2)) r = UH_W'(2);
        else if (h > UH_W'(MAX_ROWS)) r = UH_W'(MAX_ROWS);
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sgcs_item_if.sv]
`default_nettype none
// ============================================================================
// sgcs_item_if
// Input item channel: valid/ready with op, column, row and wall.
// ============================================================================
interface sgcs_item_if;
    import sgcs_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       op;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             wall;
    modport source (output valid, output op, output column, output row, output wall,
                    input ready);
    modport sink (input valid, input op, input column, input row, input wall,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/sgcs_result_if.sv]
`default_nettype none
// ============================================================================
// sgcs_result_if
// Result channel: valid/ready with ok, cell_kind and cannon_column.
// ============================================================================
interface sgcs_result_if;
    import sgcs_pkg::*;
    logic             valid;
    logic             ready;
    logic             ok;
    logic [1:0]       cell_kind;
    logic [COL_W-1:0] cannon_column;
    modport source (output valid, output ok, output cell_kind, output cannon_column,
                    input ready);
    modport sink (input valid, input ok, input cell_kind, input cannon_column,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/sgcs_front.sv]
`default_nettype none
// ============================================================================
// sgcs_front
// Accepts item beats and classifies them against the used grid size.
// ============================================================================
module sgcs_front (
    sgcs_item_if.sink               item_in,
    input  logic [sgcs_pkg::UW_W-1:0] used_width,
    input  logic [sgcs_pkg::UH_W-1:0] used_height,
    input  logic                    q_full,
    output logic                    q_push,
    output sgcs_pkg::cmd_t          q_data
);
    import sgcs_pkg::*;

    logic col_in;

    assign item_in.ready = !q_full;
    assign q_push        = item_in.valid && !q_full;
    assign col_in        = {1'b0, item_in.column} < used_width;

    always_comb
    begin
        q_data.op      = item_in.op;
        q_data.col     = item_in.column;
        q_data.row     = item_in.row;
        q_data.wall    = item_in.wall;
        q_data.col_in  = col_in;
        q_data.cell_in = col_in && ({1'b0, item_in.row} < used_height);
    end

endmodule
`default_nettype wire

[hw/rtl/sgcs_queue.sv]
`default_nettype none
// ============================================================================
// sgcs_queue
// Short command queue between the front and back parts.
// ============================================================================
module sgcs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sgcs_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output sgcs_pkg::cmd_t pop_data,
    output logic           nonempty
);
    import sgcs_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wptr_reg, rptr_reg;
    logic [QPTR_W:0]      count_reg;

    assign full     = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign nonempty = count_reg != '0;
    assign pop_data = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/sgcs_back.sv]
`default_nettype none
// ============================================================================
// sgcs_back
// Executes commands on the row-wide grid memory; one cell per cycle in a tick.
// ============================================================================
module sgcs_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  sgcs_pkg::cmd_t            q_data,
    output logic                      q_pop,
    input  logic [sgcs_pkg::UW_W-1:0] used_width,
    input  logic [sgcs_pkg::UH_W-1:0] used_height,
    input  sgcs_pkg::cfg_evt_t        cfg_evt,
    sgcs_result_if.source             result_out,
    output sgcs_pkg::back_stat_t      stat
);
    import sgcs_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RMW  = 4'd1;
    localparam logic [3:0] S_DROP = 4'd2;
    localparam logic [3:0] S_READ = 4'd3;
    localparam logic [3:0] S_TB   = 4'd4;
    localparam logic [3:0] S_TC   = 4'd5;
    localparam logic [3:0] S_TRUN = 4'd6;
    localparam logic [3:0] S_TWB  = 4'd7;
    localparam logic [3:0] S_TWC  = 4'd8;

    row_t                mem [MAX_ROWS];
    row_t                rdata_reg;
    logic                rvld_reg;
    logic [MAX_ROWS-1:0] valid_reg;

    logic [3:0]        st_reg, st_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              wall_reg, wall_next;
    logic [ROW_W-1:0]  r_reg, r_next;
    logic [COL_W-1:0]  c_reg, c_next;
    row_t              cur_reg, cur_next;
    row_t              blw_reg, blw_next;
    logic [SEED_W-1:0] lfsr_reg, lfsr_next;
    logic [COL_W-1:0]  cannon_reg, cannon_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_ok_reg, res_ok_next;
    logic [1:0]        res_kind_reg, res_kind_next;

    logic              mem_re, mem_we;
    logic [ROW_W-1:0]  raddr, waddr;
    row_t              wdata, rowdata;

    logic [COL_W-1:0]  cm1, cp1;
    logic              lfree, rfree;

    assign rowdata = rvld_reg ? rdata_reg : '0;
    assign cm1     = c_reg - 1'b1;
    assign cp1     = c_reg + 1'b1;
    assign lfree   = (c_reg != '0) && cur_reg[cm1] == KIND_EMPTY
                     && blw_reg[cm1] == KIND_EMPTY;
    assign rfree   = ({1'b0, c_reg} + 1'b1 < used_width) && cur_reg[cp1] == KIND_EMPTY
                     && blw_reg[cp1] == KIND_EMPTY;

    assign result_out.valid         = res_valid_reg;
    assign result_out.ok            = res_ok_reg;
    assign result_out.cell_kind     = res_kind_reg;
    assign result_out.cannon_column = cannon_reg;
    assign stat.busy                = st_reg != S_IDLE;
    assign stat.cannon              = cannon_reg;

    always_comb
    begin
        st_next        = st_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        wall_next      = wall_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        cur_next       = cur_reg;
        blw_next       = blw_reg;
        lfsr_next      = lfsr_reg;
        cannon_next    = cannon_reg;
        res_valid_next = res_valid_reg && !result_out.ready;
        res_ok_next    = res_ok_reg;
        res_kind_next  = res_kind_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        raddr          = '0;
        waddr          = '0;
        wdata          = rowdata;
        q_pop          = 1'b0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                begin
                    q_pop          = 1'b1;
                    col_next       = q_data.col;
                    row_next       = q_data.row;
                    wall_next      = q_data.wall;
                    res_ok_next    = 1'b1;
                    res_kind_next  = KIND_EMPTY;
                    res_valid_next = 1'b1;
                    unique case (q_data.op)
                        OP_WRITE:
                        begin
                            if (q_data.cell_in && q_data.row != '0)
                            begin
                                mem_re         = 1'b1;
                                raddr          = q_data.row;
                                res_valid_next = 1'b0;
                                st_next        = S_RMW;
                            end
                        end
                        OP_DROP_COL, OP_DROP_CANNON:
                        begin
                            if (q_data.op == OP_DROP_CANNON)
                                col_next = cannon_reg;
                            if (q_data.op == OP_DROP_CANNON || q_data.col_in)
                            begin
                                mem_re         = 1'b1;
                                raddr          = ROW_W'(1);
                                res_valid_next = 1'b0;
                                st_next        = S_DROP;
                            end
                            else
                                res_ok_next = 1'b0;
                        end
                        OP_LEFT:
                        begin
                            if (cannon_reg != '0)
                                cannon_next = cannon_reg - 1'b1;
                            else
                                res_ok_next = 1'b0;
                        end
                        OP_RIGHT:
                        begin
                            if ({1'b0, cannon_reg} + 1'b1 < used_width)
                                cannon_next = cannon_reg + 1'b1;
                            else
                                res_ok_next = 1'b0;
                        end
                        OP_TICK:
                        begin
                            if (used_height >= UH_W'(3))
                            begin
                                mem_re         = 1'b1;
                                raddr          = ROW_W'(used_height - UH_W'(1));
                                r_next         = ROW_W'(used_height - UH_W'(2));
                                res_valid_next = 1'b0;
                                st_next        = S_TB;
                            end
                        end
                        OP_READ:
                        begin
                            if (!q_data.cell_in)
                                res_kind_next = KIND_WALL;
                            else if (q_data.row == '0)
                                res_kind_next = (q_data.col == cannon_reg) ? KIND_CANNON
                                                                           : KIND_EMPTY;
                            else
                            begin
                                mem_re         = 1'b1;
                                raddr          = q_data.row;
                                res_valid_next = 1'b0;
                                st_next        = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RMW:
            begin
                wdata[col_reg] = wall_reg ? KIND_WALL : KIND_EMPTY;
                mem_we         = 1'b1;
                waddr          = row_reg;
                res_valid_next = 1'b1;
                st_next        = S_IDLE;
            end
            S_DROP:
            begin
                if (rowdata[col_reg] == KIND_EMPTY)
                begin
                    wdata[col_reg] = KIND_FLAKE;
                    mem_we         = 1'b1;
                    waddr          = ROW_W'(1);
                end
                else
                    res_ok_next = 1'b0;
                res_valid_next = 1'b1;
                st_next        = S_IDLE;
            end
            S_READ:
            begin
                res_kind_next  = rowdata[col_reg];
                res_valid_next = 1'b1;
                st_next        = S_IDLE;
            end
            S_TB:
            begin
                blw_next = rowdata;
                mem_re   = 1'b1;
                raddr    = r_reg;
                st_next  = S_TC;
            end
            S_TC:
            begin
                cur_next = rowdata;
                c_next   = COL_W'(used_width - UW_W'(1));
                st_next  = S_TRUN;
            end
            S_TRUN:
            begin
                if (cur_reg[c_reg] == KIND_FLAKE)
                begin
                    if (blw_reg[c_reg] == KIND_EMPTY)
                    begin
                        blw_next[c_reg] = KIND_FLAKE;
                        cur_next[c_reg] = KIND_EMPTY;
                    end
                    else if (blw_reg[c_reg] == KIND_FLAKE && (lfree || rfree))
                    begin
                        cur_next[c_reg] = KIND_EMPTY;
                        if (lfree && rfree)
                        begin
                            lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : '0);
                            if (lfsr_reg[0])
                                blw_next[cm1] = KIND_FLAKE;
                            else
                                blw_next[cp1] = KIND_FLAKE;
                        end
                        else if (lfree)
                            blw_next[cm1] = KIND_FLAKE;
                        else
                            blw_next[cp1] = KIND_FLAKE;
                    end
                end
                if (c_reg == '0)
                    st_next = S_TWB;
                else
                    c_next = c_reg - 1'b1;
            end
            S_TWB:
            begin
                mem_we = 1'b1;
                waddr  = r_reg + 1'b1;
                wdata  = blw_reg;
                if (r_reg == ROW_W'(1))
                    st_next = S_TWC;
                else
                begin
                    blw_next = cur_reg;
                    r_next   = r_reg - 1'b1;
                    mem_re   = 1'b1;
                    raddr    = r_reg - 1'b1;
                    st_next  = S_TC;
                end
            end
            S_TWC:
            begin
                mem_we         = 1'b1;
                waddr          = ROW_W'(1);
                wdata          = cur_reg;
                res_valid_next = 1'b1;
                st_next        = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        if (cfg_evt.seed_wr)
            lfsr_next = (cfg_evt.seed == '0) ? SEED_W'(1) : cfg_evt.seed;
        if (cfg_evt.width_wr && {1'b0, cannon_reg} > cfg_evt.width_new - UW_W'(1))
            cannon_next = COL_W'(cfg_evt.width_new - UW_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr];
        col_reg  <= col_next;
        row_reg  <= row_next;
        wall_reg <= wall_next;
        r_reg    <= r_next;
        c_reg    <= c_next;
        cur_reg  <= cur_next;
        blw_reg  <= blw_next;
        res_ok_reg   <= res_ok_next;
        res_kind_reg <= res_kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            valid_reg     <= '0;
            rvld_reg      <= 1'b0;
            lfsr_reg      <= RST_SEED;
            cannon_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            lfsr_reg      <= lfsr_next;
            cannon_reg    <= cannon_next;
            res_valid_reg <= res_valid_next;
            if (mem_re)
                rvld_reg <= valid_reg[raddr];
            if (mem_we)
                valid_reg[waddr] <= 1'b1;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/snow_grid_cellular_sweep_unit.sv]
`default_nettype none
// ============================================================================
// snow_grid_cellular_sweep_unit
// Snow grid with walls, flakes and a cannon; ticks sweep it one cell a cycle.
// ============================================================================
// channel     dir   beat
// item_in     in    op, column, row, wall
// result_out  out   ok, cell_kind, cannon_column
// apb         in    grid_width, grid_height, random_seed
//
// Cannon moves, reads outside the grid or of row 0: result straight from idle.
// Reads inside the grid read one row; writes below row 0 and drops read a row
// and write it back, a drop only into an empty cell. Tick: one cell per cycle.
// Grid rows carry valid bits; no clearing pass after reset.
// A two-beat queue lets the input side run ahead while results stall.
// ============================================================================
module snow_grid_cellular_sweep_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    sgcs_item_if.sink                      item_in,
    sgcs_result_if.source                  result_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sgcs_pkg::PADDR_W-1:0]   paddr,
    input  logic [sgcs_pkg::PDATA_W-1:0]   pwdata,
    output logic [sgcs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import sgcs_pkg::*;

    logic [UW_W-1:0]   width_reg;
    logic [UH_W-1:0]   height_reg;
    logic [SEED_W-1:0] seed_reg;
    logic [UW_W-1:0]   used_width;
    logic [UH_W-1:0]   used_height;
    logic              wr;
    logic [1:0]        idx;
    cfg_evt_t          cfg_evt;
    cmd_t              push_data, pop_data;
    logic              q_push, q_pop, q_full, q_valid;
    back_stat_t        stat;

    assign pready      = 1'b1;
    assign wr          = psel && penable && pwrite;
    assign idx         = paddr[3:2];
    assign used_width  = clamp_width(width_reg);
    assign used_height = clamp_height(height_reg);

    always_comb
    begin
        cfg_evt.width_wr  = wr && idx == REG_WIDTH;
        cfg_evt.width_new = clamp_width(pwdata[UW_W-1:0]);
        cfg_evt.seed_wr   = wr && idx == REG_SEED;
        cfg_evt.seed      = pwdata[SEED_W-1:0];
    end

    always_comb
    begin
        unique case (idx)
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_SEED:   prdata = PDATA_W'(seed_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            seed_reg   <= RST_SEED;
        end
        else if (wr)
        begin
            if (idx == REG_WIDTH)
                width_reg <= pwdata[UW_W-1:0];
            if (idx == REG_HEIGHT)
                height_reg <= pwdata[UH_W-1:0];
            if (idx == REG_SEED)
                seed_reg <= pwdata[SEED_W-1:0];
        end
    end

    sgcs_front u_front (
        .item_in     (item_in),
        .used_width  (used_width),
        .used_height (used_height),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    sgcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .nonempty  (q_valid)
    );

    sgcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .used_width  (used_width),
        .used_height (used_height),
        .cfg_evt     (cfg_evt),
        .result_out  (result_out),
        .stat        (stat)
    );

    a_cannon_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, stat.cannon} < used_width)
        else $error("cannon outside used width");

    a_back_takes_work: assert property (@(posedge clk) disable iff (!rst_n)
        (!stat.busy && q_valid && !result_out.valid) |=> (stat.busy || result_out.valid))
        else $error("back part idle with queued command");

endmodule
`default_nettype wire
